### design/value_list_append_remove_search_assert.svh
// Assertion macros for the value list block.
// ASSERT_CHECK: clocked concurrent check, disabled while reset is asserted.
// ASSERT_CHECK_ALWAYS: clocked concurrent check, also active during reset.
`ifndef VALUE_LIST_APPEND_REMOVE_SEARCH_ASSERT_SVH
`define VALUE_LIST_APPEND_REMOVE_SEARCH_ASSERT_SVH

`ifndef SYNTHESIS
`define ASSERT_CHECK(label, clock, resetn, prop) \
    label: assert property (@(posedge clock) disable iff (!resetn) prop) \
        else $error("assertion failed");
`define ASSERT_CHECK_ALWAYS(label, clock, prop) \
    label: assert property (@(posedge clock) prop) \
        else $error("assertion failed");
`else
`define ASSERT_CHECK(label, clock, resetn, prop)
`define ASSERT_CHECK_ALWAYS(label, clock, prop)
`endif

`endif

### design/vlars_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vlars_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int COUNT_W  = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;

    localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TEST   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    typedef logic signed [DATA_W-1:0] data_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // capture the transaction and compare against all held entries
        logic update;   // apply the operation and register the result
    } ctrl_cmd_t;

endpackage

`default_nettype wire

### design/value_list_append_remove_search.sv
// Channel   Handshake          Payload                       Width
// command   start / busy       mode, value                   2, 32
// result    done (strobe)      status, present, count        2, 1, 5
//
// In a transaction, the accept cycle compares the value against
// all held entries in parallel, the next cycle applies append, remove (one-step
// shift of the tail) or test. The result strobe follows in the next cycle, in
// the cycle where busy is already low, so a new command can be accepted then.
// Reset clears the count; entries are undefined until appended. The receiver
// cannot stall: each result is shown for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none

`include "value_list_append_remove_search_assert.svh"

module value_list_append_remove_search
    import vlars_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [MODE_W-1:0]    mode,
    input  wire data_t                value,
    output logic                      done,
    output logic [STATUS_W-1:0]       status,
    output logic                      present,
    output logic [COUNT_W-1:0]        count
);

    ctrl_cmd_t cmd;

    vlars_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    vlars_dp u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .mode    (mode),
        .value   (value),
        .status  (status),
        .present (present),
        .count   (count)
    );

    `ASSERT_CHECK(a_accept_goes_busy, clk, rst_n, (start && !busy) |=> (busy && !done))
    `ASSERT_CHECK(a_busy_then_result, clk, rst_n, busy |=> (done && !busy))
    `ASSERT_CHECK(a_count_bounded, clk, rst_n, done |-> (count <= COUNT_W'(CAPACITY)))
    `ASSERT_CHECK(a_full_only_when_full, clk, rst_n, (done && (status == ST_FULL)) |-> (count == COUNT_W'(CAPACITY) && !present))
    `ASSERT_CHECK_ALWAYS(a_no_busy_in_reset, clk, !rst_n |-> (!busy && !done))

endmodule

`default_nettype wire

### design/vlars_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module vlars_ctrl
    import vlars_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    output ctrl_cmd_t      cmd,
    output logic           busy,
    output logic           done
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic done_reg;
    logic done_next;

    always_comb
    begin
        cmd.load   = (state_reg == S_IDLE) && start;
        cmd.update = (state_reg == S_EXEC);
        done_next  = cmd.update;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg == S_EXEC);
    assign done = done_reg;

endmodule

`default_nettype wire

### design/vlars_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module vlars_dp
    import vlars_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire ctrl_cmd_t            cmd,
    input  wire logic [MODE_W-1:0]    mode,
    input  wire data_t                value,
    output logic [STATUS_W-1:0]       status,
    output logic                      present,
    output logic [COUNT_W-1:0]        count
);

    data_t                entries_reg [CAPACITY];
    data_t                entries_next [CAPACITY];
    logic [COUNT_W-1:0]   fill_reg;
    logic [COUNT_W-1:0]   fill_next;
    logic [CAPACITY-1:0]  match_reg;
    logic [CAPACITY-1:0]  match_next;
    logic [MODE_W-1:0]    mode_reg;
    logic [MODE_W-1:0]    mode_next;
    data_t                value_reg;
    data_t                value_next;
    logic [STATUS_W-1:0]  status_reg;
    logic [STATUS_W-1:0]  status_next;
    logic                 present_reg;
    logic                 present_next;
    logic [CAPACITY-1:0]  tail;
    logic                 hit;

    // tail[i]: entry i sits at or past the first match, so it takes its upper neighbor
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            tail[i] = |(match_reg << (CAPACITY - 1 - i));
        end
        hit = |match_reg;
    end

    always_comb
    begin
        entries_next = entries_reg;
        fill_next    = fill_reg;
        match_next   = match_reg;
        mode_next    = mode_reg;
        value_next   = value_reg;
        status_next  = status_reg;
        present_next = present_reg;

        if (cmd.load)
        begin
            mode_next  = mode;
            value_next = value;
            for (int i = 0; i < CAPACITY; i++)
            begin
                match_next[i] = (entries_reg[i] == value) && (COUNT_W'(i) < fill_reg);
            end
        end

        if (cmd.update)
        begin
            status_next  = ST_DONE;
            present_next = 1'b0;
            case (mode_reg)
                MODE_APPEND:
                begin
                    if (fill_reg == COUNT_W'(CAPACITY))
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        entries_next[fill_reg[IDX_W-1:0]] = value_reg;
                        fill_next = fill_reg + COUNT_W'(1);
                    end
                end
                MODE_REMOVE:
                begin
                    if (hit)
                    begin
                        present_next = 1'b1;
                        for (int i = 0; i < CAPACITY - 1; i++)
                        begin
                            if (tail[i])
                            begin
                                entries_next[i] = entries_reg[i + 1];
                            end
                        end
                        fill_next = fill_reg - COUNT_W'(1);
                    end
                    else
                    begin
                        status_next = ST_MISS;
                    end
                end
                MODE_TEST:
                begin
                    if (hit)
                    begin
                        present_next = 1'b1;
                    end
                    else
                    begin
                        status_next = ST_MISS;
                    end
                end
                default:
                begin
                    // unused mode: drop the transaction, report done
                    status_next = ST_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entries_reg <= entries_next;
        match_reg   <= match_next;
        mode_reg    <= mode_next;
        value_reg   <= value_next;
        status_reg  <= status_next;
        present_reg <= present_next;
    end

    assign status  = status_reg;
    assign present = present_reg;
    assign count   = fill_reg;

endmodule

`default_nettype wire

### verif/tb.sv
`timescale 1ns / 1ps

module tb;
    import vlars_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 2000;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct {
        logic [MODE_W-1:0] op;
        data_t             operand;
        bit                drain;   // wait for every reply before sending
        bit                steady;  // no random gap before this one
    } list_cmd_t;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic                present;
        logic [COUNT_W-1:0]  count;
    } list_reply_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [MODE_W-1:0]   mode;
    data_t               value;
    logic                done;
    logic [STATUS_W-1:0] status;
    logic                present;
    logic [COUNT_W-1:0]  count;

    value_list_append_remove_search uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .mode    (mode),
        .value   (value),
        .done    (done),
        .status  (status),
        .present (present),
        .count   (count)
    );

    list_cmd_t   cmd_q[$];
    list_reply_t awaited_replies[$];
    data_t       shadow_list[CAPACITY];
    int          shadow_fill = 0;
    int          in_flight = 0;
    int          mismatches = 0;
    int          cycle_count = 0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic void queue_cmd(logic [MODE_W-1:0] op, data_t operand, bit drain,
                                      bit steady);
        list_cmd_t c;
        c.op      = op;
        c.operand = operand;
        c.drain   = drain;
        c.steady  = steady;
        cmd_q.push_back(c);
    endfunction

    // Apply one transaction to the shadow list and return the reply it must produce.
    function automatic list_reply_t apply_list_op(logic [MODE_W-1:0] op, data_t operand);
        list_reply_t r;
        int          hit;
        r.status  = ST_DONE;
        r.present = 1'b0;
        hit = -1;
        for (int i = 0; i < shadow_fill; i++)
        begin
            if (hit < 0 && shadow_list[i] == operand)
                hit = i;
        end
        case (op)
            MODE_APPEND:
            begin
                if (shadow_fill >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    shadow_list[shadow_fill] = operand;
                    shadow_fill++;
                end
            end
            MODE_REMOVE:
            begin
                if (hit < 0)
                    r.status = ST_MISS;
                else
                begin
                    r.present = 1'b1;
                    // shift the tail down over the removed entry
                    for (int i = hit; i < shadow_fill - 1; i++)
                        shadow_list[i] = shadow_list[i + 1];
                    shadow_fill--;
                end
            end
            MODE_TEST:
            begin
                if (hit < 0)
                    r.status = ST_MISS;
                else
                    r.present = 1'b1;
            end
            default:
            begin
            end
        endcase
        r.count = shadow_fill[COUNT_W-1:0];
        return r;
    endfunction

    // Driver: hold the command while busy, otherwise pop the next one or idle.
    always @(posedge clk)
    begin : driver
        list_reply_t r;
        list_cmd_t   c;
        bit          hold_off;
        if (rst_n)
        begin
            if (done)
                in_flight--;
            if (start && !busy)
            begin
                r = apply_list_op(mode, value);
                awaited_replies.push_back(r);
                in_flight++;
            end
            if (start && busy)
            begin
            end
            else if (cmd_q.size() != 0)
            begin
                c = cmd_q[0];
                hold_off = (c.drain && in_flight != 0) ||
                           (!c.steady && $urandom_range(99) < 17);
                if (hold_off)
                    start <= 1'b0;
                else
                begin
                    c = cmd_q.pop_front();
                    start <= 1'b1;
                    mode  <= c.op;
                    value <= c.operand;
                end
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: every strobed reply is checked against the oldest prediction.
    always @(posedge clk)
    begin : monitor
        list_reply_t e;
        if (rst_n && done)
        begin
            if (awaited_replies.size() == 0)
            begin
                $error("reply with no transaction outstanding: status %0d present %0d count %0d",
                       status, present, count);
                mismatches++;
            end
            else
            begin
                e = awaited_replies.pop_front();
                if (status !== e.status)
                begin
                    $error("status mismatch: expected %0d, actual %0d", e.status, status);
                    mismatches++;
                end
                if (present !== e.present)
                begin
                    $error("present mismatch: expected %0d, actual %0d", e.present, present);
                    mismatches++;
                end
                if (count !== e.count)
                begin
                    $error("count mismatch: expected %0d, actual %0d", e.count, count);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin : stimulus
        data_t pool[8];
        int    bias;
        int    roll;
        logic [MODE_W-1:0] op;
        data_t operand;

        rst_n = 1'b1;
        start = 1'b0;
        mode  = MODE_APPEND;
        value = '0;
        // drop reset just after time zero so the asynchronous reset sees a clean edge
        #1 rst_n = 1'b0;

        // empty list: misses and an ignored mode
        queue_cmd(MODE_REMOVE, 32'sd0, 0, 0);
        queue_cmd(MODE_TEST, 32'sd0, 0, 0);
        queue_cmd(MODE_UNUSED, 32'sh7FFFFFFF, 0, 0);
        // field extremes
        queue_cmd(MODE_APPEND, 32'sh80000000, 0, 0);
        queue_cmd(MODE_APPEND, 32'sh7FFFFFFF, 0, 0);
        queue_cmd(MODE_APPEND, 32'sd0, 0, 0);
        queue_cmd(MODE_APPEND, -32'sd1, 0, 0);
        queue_cmd(MODE_APPEND, 32'sh55555555, 0, 0);
        queue_cmd(MODE_APPEND, 32'shAAAAAAAA, 0, 0);
        queue_cmd(MODE_TEST, 32'shAAAAAAAA, 0, 0);      // last held entry
        queue_cmd(MODE_REMOVE, 32'sh80000000, 0, 0);    // first entry, whole tail shifts
        queue_cmd(MODE_TEST, 32'sh80000000, 0, 0);
        // fill to capacity, with duplicates of held values
        for (int i = 0; i < 11; i++)
            queue_cmd(MODE_APPEND, (i % 3 == 0) ? -32'sd1 : data_t'(i * 32'h01010101), 0, 0);
        queue_cmd(MODE_APPEND, 32'sd12345, 0, 0);       // full, dropped
        queue_cmd(MODE_REMOVE, -32'sd1, 0, 0);          // first of several duplicates
        queue_cmd(MODE_REMOVE, 32'sd12345, 0, 0);       // not held

        bias = 0;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 50 == 0)
            begin
                for (int k = 0; k < 8; k++)
                    pool[k] = data_t'($urandom);
                if ($urandom_range(3) == 0)
                begin
                    pool[0] = 32'sh80000000;
                    pool[1] = 32'sh7FFFFFFF;
                    pool[2] = 32'sd0;
                    pool[3] = -32'sd1;
                end
                bias = $urandom_range(2);
            end
            roll = $urandom_range(99);
            if (roll < 3)
                op = MODE_UNUSED;
            else if (bias == 0)
                op = (roll < 65) ? MODE_APPEND : (roll < 82) ? MODE_REMOVE : MODE_TEST;
            else if (bias == 1)
                op = (roll < 30) ? MODE_APPEND : (roll < 75) ? MODE_REMOVE : MODE_TEST;
            else
                op = (roll < 45) ? MODE_APPEND : (roll < 72) ? MODE_REMOVE : MODE_TEST;
            operand = ($urandom_range(99) < 85) ? pool[$urandom_range(7)] : data_t'($urandom);
            queue_cmd(op, operand, (i == 1000) || ($urandom_range(199) == 0),
                      (i >= 1200) && (i < 1500));
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (cmd_q.size() != 0 || start || awaited_replies.size() != 0)
            @(negedge clk);
        repeat (8) @(posedge clk);

        if (awaited_replies.size() != 0)
        begin
            $error("%0d predicted replies never arrived", awaited_replies.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
